// ===== rtl/ccr_pkg.sv =====
package ccr_pkg;

   // Datapath widths
   localparam int XW = 64;   // vectoring x/y
   localparam int AW = 34;   // angle accumulator, Q2.30 plus headroom
   localparam int CW = 34;   // rotation cos/sin

   localparam int PRESCALE   = 28;
   localparam int ANGLE_BITS = 30;

   localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
   // floor(n/3) == (n * RECIP3) >> 33 for any 32-bit n
   localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
   localparam int          RECIP3_SHR = 33;

   typedef struct packed {
      logic signed [31:0] z_real;
      logic signed [31:0] z_imag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] root_real;
      logic signed [31:0] root_imag;
   } rsp_type;

   // Everything one item carries down the pipeline
   typedef struct packed {
      logic                 neg;
      logic [31:0]          p;
      logic signed [32:0]   q;
      logic [63:0]          sq_p;
      logic [63:0]          sq_q;
      logic [63:0]          rad;    // square root remainder
      logic [63:0]          res;    // square root result
      logic [63:0]          rem;    // cube root remainder
      logic [31:0]          cy;     // cube root result
      logic [63:0]          cysq;   // cy * cy
      logic signed [XW-1:0] vx;
      logic signed [XW-1:0] vy;
      logic signed [AW-1:0] ang;
      logic [63:0]          quot;
      logic signed [CW-1:0] rc;
      logic signed [CW-1:0] rs;
      logic signed [63:0]   pre;
      logic signed [63:0]   pim;
      rsp_type              out;
   } stage_type;

   // Arctangent of 2^-idx in Q2.30 radians
   function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [AW-1:0] a;
      unique case (idx)
         5'd0:  a = 34'sd843314856;
         5'd1:  a = 34'sd497837829;
         5'd2:  a = 34'sd263043836;
         5'd3:  a = 34'sd133525158;
         5'd4:  a = 34'sd67021686;
         5'd5:  a = 34'sd33543515;
         5'd6:  a = 34'sd16775850;
         5'd7:  a = 34'sd8388437;
         5'd8:  a = 34'sd4194282;
         5'd9:  a = 34'sd2097149;
         5'd10: a = 34'sd1048575;
         5'd11: a = 34'sd524287;
         5'd12: a = 34'sd262143;
         5'd13: a = 34'sd131071;
         5'd14: a = 34'sd65535;
         5'd15: a = 34'sd32767;
         5'd16: a = 34'sd16383;
         5'd17: a = 34'sd8191;
         5'd18: a = 34'sd4095;
         5'd19: a = 34'sd2047;
         5'd20: a = 34'sd1023;
         5'd21: a = 34'sd511;
         5'd22: a = 34'sd255;
         5'd23: a = 34'sd127;
         5'd24: a = 34'sd63;
         5'd25: a = 34'sd31;
         5'd26: a = 34'sd15;
         5'd27: a = 34'sd8;
         5'd28: a = 34'sd4;
         5'd29: a = 34'sd2;
         5'd30: a = 34'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/ccr_cordic_step.sv =====
module ccr_cordic_step #(
   parameter int W         = 64,
   parameter int SHIFT     = 0,
   parameter bit VECTORING = 1'b0
) (
   input  logic signed [W-1:0]           x_i,
   input  logic signed [W-1:0]           y_i,
   input  logic signed [ccr_pkg::AW-1:0] z_i,
   output logic signed [W-1:0]           x_o,
   output logic signed [W-1:0]           y_o,
   output logic signed [ccr_pkg::AW-1:0] z_o
);
   import ccr_pkg::*;

   logic                 up;
   logic signed [W-1:0]  dx;
   logic signed [W-1:0]  dy;
   logic signed [AW-1:0] a;

   // Vectoring drives y toward zero, rotation drives z toward zero
   always_comb begin
      up = VECTORING ? y_i[W-1] : !z_i[AW-1];
      dx = y_i >>> SHIFT;
      dy = x_i >>> SHIFT;
      a  = atan_q30(5'(SHIFT));
      if (up) begin
         x_o = x_i - dx;
         y_o = y_i + dy;
         z_o = z_i - a;
      end else begin
         x_o = x_i + dx;
         y_o = y_i - dy;
         z_o = z_i + a;
      end
   end

endmodule

// ===== rtl/complex_cube_root.sv =====
// Throughput: one item per cycle while the output stage is empty or being taken;
//   every square root, cube root and CORDIC step has its own pipeline stage, and the
//   whole pipe advances together.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
module complex_cube_root #(
   parameter int ITERATIONS = 20,
   parameter int FRAC_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ccr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ccr_pkg::rsp_type rsp_data
);
   import ccr_pkg::*;

   localparam int N     = (ITERATIONS > 32) ? 32 : ITERATIONS;
   localparam int LOW   = 2 * FRAC_BITS;
   localparam int G     = (32 + LOW + 2) / 3;
   localparam int S_RT0 = 3;
   localparam int S_CB0 = S_RT0 + 32;
   localparam int S_VC0 = S_CB0 + G;
   localparam int S_D1  = S_VC0 + N;
   localparam int S_D2  = S_D1 + 1;
   localparam int S_RO0 = S_D2 + 1;
   localparam int S_M1  = S_RO0 + N;
   localparam int S_M2  = S_M1 + 1;
   localparam int NS    = S_M2 + 1;

   stage_type        st_ff [NS];
   stage_type        st_in [NS];
   logic [NS-1:0]    vld_ff;
   logic             adv;

   // Whole pipe moves when the last stage is empty or being taken
   assign adv       = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data  = st_ff[NS-1].out;

   // Stage 0: fold the left half plane onto the right one
   always_comb begin
      logic signed [32:0] qe;
      st_in[0]     = '0;
      qe           = {req_data.z_imag[31], req_data.z_imag};
      st_in[0].neg = req_data.z_real[31];
      st_in[0].p   = req_data.z_real[31] ? 32'(-req_data.z_real) : 32'(req_data.z_real);
      st_in[0].q   = req_data.z_real[31] ? -qe : qe;
   end

   for (genvar k = 1; k < NS; k++) begin : g_st
      if (k == 1) begin : g_sq
         // squares of both parts
         always_comb begin
            logic [32:0] qa;
            st_in[k]      = st_ff[k-1];
            qa            = st_ff[k-1].q[32] ? 33'(-st_ff[k-1].q) : 33'(st_ff[k-1].q);
            st_in[k].sq_p = {32'b0, st_ff[k-1].p} * {32'b0, st_ff[k-1].p};
            st_in[k].sq_q = {32'b0, qa[31:0]} * {32'b0, qa[31:0]};
         end
      end else if (k == 2) begin : g_sum
         always_comb begin
            st_in[k]     = st_ff[k-1];
            st_in[k].rad = st_ff[k-1].sq_p + st_ff[k-1].sq_q;
            st_in[k].res = '0;
         end
      end else if (k < S_CB0) begin : g_sqrt
         // one result bit of the modulus per stage
         localparam logic [63:0] BIT = 64'(1) << (62 - 2 * (k - S_RT0));
         always_comb begin
            logic [63:0] t;
            st_in[k] = st_ff[k-1];
            t        = st_ff[k-1].res + BIT;
            if (st_ff[k-1].rad >= t) begin
               st_in[k].rad = st_ff[k-1].rad - t;
               st_in[k].res = (st_ff[k-1].res >> 1) + BIT;
            end else begin
               st_in[k].res = st_ff[k-1].res >> 1;
            end
         end
      end else if (k < S_VC0) begin : g_cbrt
         // one 3-bit group of r * 2^LOW per stage
         localparam int GRP = G - 1 - (k - S_CB0);
         always_comb begin
            logic [3*G-1:0] vsrc;
            logic [2:0]     digit;
            logic [63:0]    rem_p, ysq_p, rem2, ysq2, y2, t;
            logic [31:0]    y_p;
            st_in[k] = st_ff[k-1];
            vsrc     = (3*G)'(st_ff[k-1].res[31:0]) << LOW;
            digit    = vsrc[3*GRP +: 3];
            rem_p    = (k == S_CB0) ? '0 : st_ff[k-1].rem;
            y_p      = (k == S_CB0) ? '0 : st_ff[k-1].cy;
            ysq_p    = (k == S_CB0) ? '0 : st_ff[k-1].cysq;
            rem2     = {rem_p[60:0], digit};
            y2       = {31'b0, y_p, 1'b0};
            ysq2     = ysq_p << 2;
            t        = 3 * (ysq2 + y2) + 64'd1;
            if (rem2 >= t) begin
               st_in[k].rem  = rem2 - t;
               st_in[k].cy   = 32'(y2 + 64'd1);
               st_in[k].cysq = ysq2 + (y2 << 1) + 64'd1;
            end else begin
               st_in[k].rem  = rem2;
               st_in[k].cy   = 32'(y2);
               st_in[k].cysq = ysq2;
            end
         end
      end else if (k < S_D1) begin : g_vec
         logic signed [XW-1:0] xi, yi, xo, yo;
         logic signed [AW-1:0] zi, zo;
         always_comb begin
            if (k == S_VC0) begin
               xi = $signed(64'(st_ff[k-1].p) << PRESCALE);
               yi = 64'(st_ff[k-1].q) <<< PRESCALE;
               zi = '0;
            end else begin
               xi = st_ff[k-1].vx;
               yi = st_ff[k-1].vy;
               zi = st_ff[k-1].ang;
            end
         end
         ccr_cordic_step #(.W(XW), .SHIFT(k - S_VC0), .VECTORING(1'b1)) u_step (
            .x_i(xi), .y_i(yi), .z_i(zi), .x_o(xo), .y_o(yo), .z_o(zo)
         );
         always_comb begin
            st_in[k]     = st_ff[k-1];
            st_in[k].vx  = xo;
            st_in[k].vy  = yo;
            st_in[k].ang = zo;
         end
      end else if (k == S_D1) begin : g_div_mul
         // |theta| times the reciprocal of three
         always_comb begin
            logic [AW-1:0] za;
            st_in[k]      = st_ff[k-1];
            za            = st_ff[k-1].ang[AW-1] ? AW'(-st_ff[k-1].ang) : st_ff[k-1].ang;
            st_in[k].quot = {32'b0, za[31:0]} * {32'b0, RECIP3};
         end
      end else if (k == S_D2) begin : g_div_fix
         always_comb begin
            logic signed [AW-1:0] qv;
            st_in[k]     = st_ff[k-1];
            qv           = $signed(AW'(st_ff[k-1].quot >> RECIP3_SHR));
            st_in[k].ang = st_ff[k-1].ang[AW-1] ? -qv : qv;
         end
      end else if (k < S_M1) begin : g_rot
         logic signed [CW-1:0] xi, yi, xo, yo;
         logic signed [AW-1:0] zi, zo;
         always_comb begin
            if (k == S_RO0) begin
               xi = INV_GAIN;
               yi = '0;
            end else begin
               xi = st_ff[k-1].rc;
               yi = st_ff[k-1].rs;
            end
            zi = st_ff[k-1].ang;
         end
         ccr_cordic_step #(.W(CW), .SHIFT(k - S_RO0), .VECTORING(1'b0)) u_step (
            .x_i(xi), .y_i(yi), .z_i(zi), .x_o(xo), .y_o(yo), .z_o(zo)
         );
         always_comb begin
            st_in[k]     = st_ff[k-1];
            st_in[k].rc  = xo;
            st_in[k].rs  = yo;
            st_in[k].ang = zo;
         end
      end else if (k == S_M1) begin : g_mul
         // magnitude times cos and sin
         always_comb begin
            logic signed [63:0] mx;
            st_in[k]     = st_ff[k-1];
            mx           = $signed({32'b0, st_ff[k-1].cy});
            st_in[k].pre = mx * 64'(st_ff[k-1].rc);
            st_in[k].pim = mx * 64'(st_ff[k-1].rs);
         end
      end else begin : g_out
         always_comb begin
            logic signed [63:0] re, im;
            st_in[k]  = st_ff[k-1];
            re        = st_ff[k-1].pre >>> ANGLE_BITS;
            im        = st_ff[k-1].pim >>> ANGLE_BITS;
            if (st_ff[k-1].neg) begin
               re = -re;
               im = -im;
            end
            st_in[k].out.root_real = re[31:0];
            st_in[k].out.root_imag = im[31:0];
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   // Stage data
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NS; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

endmodule

// ===== rtl/ccr_checker.sv =====
module ccr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ccr_pkg::rsp_type rsp_data
);
   import ccr_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // empty output never blocks input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a result transfer frees the pipe for a new input
   a_ready_xfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input stalled during result transfer");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind complex_cube_root ccr_checker u_ccr_checker (.*);
